FILE: rtl/iff_pkg.sv
// Shared constants, widths and types of the integer field formatter.
`timescale 1ns / 1ps
package iff_pkg;

	// Field widths at the ports
	localparam int IN_VALUE_W = 64;
	localparam int BASE_W     = 2;
	localparam int FW_W       = 6;
	localparam int CHAR_W     = 8;

	// Sizing constants
	localparam int MAX_WIDTH  = 40;
	localparam int VALUE_BITS = 64;

	// Digit counts for the value width; octal always needs the most digits
	localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int NDIG       = (VALUE_BITS + 2) / 3;
	localparam int ND_W       = $clog2(NDIG + 1);
	localparam int BC_W       = $clog2(VALUE_BITS + 1);

	// Longest field: padded width or sign, two prefix characters and all digits
	localparam int TEXT_MAX   = NDIG + 3;
	localparam int LEN_MAX    = (MAX_WIDTH > TEXT_MAX) ? MAX_WIDTH : TEXT_MAX;
	localparam int LEN_CLOG   = $clog2(LEN_MAX + 1);
	localparam int CNT_W      = (LEN_CLOG > FW_W + 1) ? LEN_CLOG : FW_W + 1;

	// Radix codes
	localparam logic [BASE_W-1:0] BASE_OCT = 2'd0;
	localparam logic [BASE_W-1:0] BASE_DEC = 2'd1;
	localparam logic [BASE_W-1:0] BASE_HEX = 2'd2;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef logic [3:0] digit_t;
	typedef digit_t [NDIG-1:0] dig_vec_t;
	typedef digit_t [DEC_DIGITS-1:0] bcd_vec_t;

	localparam digit_t DIGIT_ZERO = 4'd0;

	// Commands to the digit register
	typedef struct packed {
		logic load;
		logic strip;
		logic pop;
	} dig_cmd_t;

	// Status from the digit register
	typedef struct packed {
		digit_t          msd;
		logic [ND_W-1:0] nd;
		logic            strip_done;
	} dig_sts_t;

endpackage

FILE: rtl/integer_field_formatter_core.sv
// Top level of the integer field formatter: request capture, field sequencer, output register.
`timescale 1ns / 1ps
// One request in, one ASCII character out per transfer, the final character flagged by
// last_char. The block holds one request at a time and keeps in_stall high from the
// accepting edge until the last character is loaded into the output register; the next
// request can then be taken while that character still waits. Before the output side can
// stall it, a request passes through capture, then for decimal the bit-serial BCD converter
// (one value bit per cycle; octal and hex skip it, their digits being the value bits
// themselves), the leading-zero strip of the 22-digit register (at most 21 digits, one
// digit a cycle), and the field phases (spaces, sign, prefix, zeros, digits, trailing
// spaces). The field length is the larger of the saturated width and the text.
module integer_field_formatter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [iff_pkg::IN_VALUE_W-1:0]      value,
	input  logic                                signed_conv,
	input  logic [iff_pkg::BASE_W-1:0]          base_code,
	input  logic                                upper_case,
	input  logic                                alt_form,
	input  logic                                zero_pad,
	input  logic                                left_align,
	input  logic [iff_pkg::FW_W-1:0]            field_width,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [iff_pkg::CHAR_W-1:0]          char_code,
	output logic                                last_char
);

	localparam int VB = iff_pkg::VALUE_BITS;
	localparam int CW = iff_pkg::CNT_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_CONV = 3'd2;
	localparam logic [2:0] ST_NORM = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// Field phases, in output order
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_LSP   = 3'd1;
	localparam logic [2:0] PH_SIGN  = 3'd2;
	localparam logic [2:0] PH_PFX0  = 3'd3;
	localparam logic [2:0] PH_PFXX  = 3'd4;
	localparam logic [2:0] PH_ZPAD  = 3'd5;
	localparam logic [2:0] PH_DIG   = 3'd6;
	localparam logic [2:0] PH_TSP   = 3'd7;

	logic [2:0]                     state_q;
	logic [2:0]                     phase_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  tot_q;
	logic                           out_valid_q;

	// Request payload, held for the whole field
	logic [VB-1:0]                  mag_q;
	logic                           neg_q;
	logic [iff_pkg::BASE_W-1:0]     base_q;
	logic                           uc_q;
	logic                           lz_q;
	logic                           left_q;
	logic [1:0]                     pfx_q;
	logic [CW-1:0]                  width_q;
	logic [CW-1:0]                  pad_q;
	logic [iff_pkg::CHAR_W-1:0]     char_q;
	logic                           last_q;

	logic                           accept;
	logic                           out_free;
	logic                           emit;
	logic [VB-1:0]                  v_in;
	logic                           neg_in;
	logic [VB-1:0]                  mag_in;
	logic [1:0]                     pfx_in;
	logic [CW-1:0]                  fw_ext;
	logic [CW-1:0]                  text_len;
	logic [2:0]                     phase_nxt;
	logic [CW-1:0]                  len_nxt;
	logic [iff_pkg::CHAR_W-1:0]     ch;
	logic [iff_pkg::CHAR_W-1:0]     dig_ch;
	logic [iff_pkg::VALUE_BITS-1:0] bcd_bin;
	logic [4*iff_pkg::NDIG-1:0]     mag_ext;

	iff_pkg::bcd_vec_t              bcd;
	logic                           bcd_done;
	logic                           bcd_start;
	iff_pkg::dig_cmd_t              dcmd;
	iff_pkg::dig_sts_t              dsts;
	iff_pkg::dig_vec_t              load_dig;

	// Request capture: magnitude, sign and prefix length
	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	assign v_in   = value[VB-1:0];
	assign neg_in = signed_conv && v_in[VB-1];
	assign mag_in = neg_in ? (~v_in + VB'(1)) : v_in;
	assign fw_ext = CW'(field_width);

	always_comb begin
		case (base_code)
			iff_pkg::BASE_OCT: pfx_in = 2'd1;
			default:           pfx_in = 2'd2;
		endcase
		if (base_code == iff_pkg::BASE_DEC) begin
			pfx_in = 2'd0;
		end
		if (!alt_form || (v_in == '0)) begin
			pfx_in = 2'd0;
		end
	end

	// Digit source: BCD for decimal, bit groups of the magnitude otherwise
	assign mag_ext = (4*iff_pkg::NDIG)'(mag_q);
	assign bcd_bin = mag_q;

	always_comb begin
		for (int i = 0; i < iff_pkg::NDIG; i++) begin
			if (base_q == iff_pkg::BASE_DEC) begin
				load_dig[i] = (i < iff_pkg::DEC_DIGITS) ? bcd[i] : iff_pkg::DIGIT_ZERO;
			end else if (base_q == iff_pkg::BASE_OCT) begin
				load_dig[i] = {1'b0, mag_ext[3*i +: 3]};
			end else begin
				load_dig[i] = mag_ext[4*i +: 4];
			end
		end
	end

	assign bcd_start  = (state_q == ST_PREP) && (base_q == iff_pkg::BASE_DEC);
	assign dcmd.load  = ((state_q == ST_PREP) && (base_q != iff_pkg::BASE_DEC)) ||
	                    ((state_q == ST_CONV) && bcd_done);
	assign dcmd.strip = (state_q == ST_NORM);
	assign dcmd.pop   = emit && (phase_q == PH_DIG);

	iff_bcd_conv u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (bcd_bin),
		.bcd    (bcd),
		.done   (bcd_done)
	);

	iff_digit_reg u_dig (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dcmd),
		.load_dig (load_dig),
		.sts      (dsts)
	);

	// Text length once the digit count is settled
	assign text_len = CW'(dsts.nd) + CW'(neg_q) + CW'(pfx_q);

	// Length of the phase the sequencer moves into next
	assign phase_nxt = phase_q + 3'd1;
	always_comb begin
		unique case (phase_nxt)
			PH_LSP:  len_nxt = (!lz_q && !left_q) ? pad_q : '0;
			PH_SIGN: len_nxt = CW'(neg_q);
			PH_PFX0: len_nxt = CW'(pfx_q != 2'd0);
			PH_PFXX: len_nxt = CW'(pfx_q == 2'd2);
			PH_ZPAD: len_nxt = lz_q ? pad_q : '0;
			PH_DIG:  len_nxt = CW'(dsts.nd);
			PH_TSP:  len_nxt = left_q ? pad_q : '0;
			default: len_nxt = '0;
		endcase
	end

	// Character of the current phase
	always_comb begin
		if (dsts.msd < 4'd10) begin
			dig_ch = iff_pkg::CH_ZERO + iff_pkg::CHAR_W'(dsts.msd);
		end else begin
			dig_ch = (uc_q ? iff_pkg::CH_UA : iff_pkg::CH_LA) +
			         iff_pkg::CHAR_W'(dsts.msd) - iff_pkg::CHAR_W'(10);
		end
		case (phase_q) inside
			PH_SIGN:          ch = iff_pkg::CH_MINUS;
			PH_PFX0, PH_ZPAD: ch = iff_pkg::CH_ZERO;
			PH_PFXX:          ch = uc_q ? iff_pkg::CH_UX : iff_pkg::CH_LX;
			PH_DIG:           ch = dig_ch;
			default:          ch = iff_pkg::CH_SPACE;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_EMIT) && (cnt_q != '0) && out_free;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_START;
			cnt_q       <= '0;
			tot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new character, or drop the held one once the sink takes it
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= (base_q == iff_pkg::BASE_DEC) ? ST_CONV : ST_NORM;
				end
				ST_CONV: begin
					if (bcd_done) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					// Hold until the leading zeros are gone, then size the field
					if (dsts.strip_done) begin
						tot_q   <= (width_q > text_len) ? width_q : text_len;
						phase_q <= PH_START;
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cnt_q == '0) begin
						// Advance to the next phase, empty ones included
						phase_q <= phase_nxt;
						cnt_q   <= len_nxt;
					end else if (out_free) begin
						cnt_q       <= cnt_q - CW'(1);
						tot_q       <= tot_q - CW'(1);
						if (tot_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= mag_in;
			neg_q   <= neg_in;
			base_q  <= base_code;
			uc_q    <= upper_case;
			lz_q    <= zero_pad && !left_align;
			left_q  <= left_align;
			pfx_q   <= pfx_in;
			width_q <= (fw_ext > CW'(iff_pkg::MAX_WIDTH)) ? CW'(iff_pkg::MAX_WIDTH) : fw_ext;
		end
		if ((state_q == ST_NORM) && dsts.strip_done) begin
			pad_q <= (width_q > text_len) ? (width_q - text_len) : '0;
		end
		if (emit) begin
			char_q <= ch;
			last_q <= (tot_q == CW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	// A field in flight always has characters left to send
	a_tot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (tot_q != '0))
		else $error("field sequencer running with no characters left");

	// Loading the final character frees the input side on the next cycle
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (tot_q == CW'(1))) |=> (!in_stall && out_valid && last_char))
		else $error("final character did not release the input side");

	// Digits are only popped while some remain in the register
	a_pop_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.pop |-> ((cnt_q <= CW'(dsts.nd)) && (dsts.nd != '0)))
		else $error("digit popped beyond the digit count");

	// An accepted request starts the conversion on the next cycle
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PREP))
		else $error("accepted request did not start");

endmodule

FILE: rtl/iff_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add three).
`timescale 1ns / 1ps
module iff_bcd_conv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [iff_pkg::VALUE_BITS-1:0]  bin,
	output iff_pkg::bcd_vec_t               bcd,
	output logic                            done
);

	logic [iff_pkg::VALUE_BITS-1:0] bin_q;
	iff_pkg::bcd_vec_t              bcd_q;
	iff_pkg::bcd_vec_t              adj;
	iff_pkg::bcd_vec_t              bcd_nxt;
	logic [iff_pkg::BC_W-1:0]       cnt_q;
	logic                           busy_q;
	logic                           done_q;

	// Correct each digit, then shift one binary bit in at the bottom
	always_comb begin
		for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_nxt[0] = {adj[0][2:0], bin_q[iff_pkg::VALUE_BITS-1]};
		for (int i = 1; i < iff_pkg::DEC_DIGITS; i++) begin
			bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == iff_pkg::BC_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iff_pkg::BC_W'(iff_pkg::VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - iff_pkg::BC_W'(1);
				if (cnt_q == iff_pkg::BC_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[iff_pkg::VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_nxt;
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

FILE: rtl/iff_digit_reg.sv
// Digit shift register: strips leading zeros and pops digits most significant first.
`timescale 1ns / 1ps
module iff_digit_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  iff_pkg::dig_cmd_t   cmd,
	input  iff_pkg::dig_vec_t   load_dig,
	output iff_pkg::dig_sts_t   sts
);

	iff_pkg::dig_vec_t           dig_q;
	logic [iff_pkg::ND_W-1:0]    nd_q;
	logic                        strip_done;

	// Stop at a non-zero leading digit or at the single remaining digit
	assign strip_done = (dig_q[iff_pkg::NDIG-1] != iff_pkg::DIGIT_ZERO) ||
	                    (nd_q == iff_pkg::ND_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= '0;
		end else if (cmd.load) begin
			nd_q <= iff_pkg::ND_W'(iff_pkg::NDIG);
		end else if (cmd.strip && !strip_done) begin
			nd_q <= nd_q - iff_pkg::ND_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dig_q <= load_dig;
		end else if ((cmd.strip && !strip_done) || cmd.pop) begin
			dig_q <= {dig_q[iff_pkg::NDIG-2:0], iff_pkg::DIGIT_ZERO};
		end
	end

	assign sts.msd        = dig_q[iff_pkg::NDIG-1];
	assign sts.nd         = nd_q;
	assign sts.strip_done = strip_done;

endmodule
